>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the ALU block.
// Each macro expands to one labeled concurrent assertion on the clk edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define IALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define IALU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ialu_pkg.sv
// Package for the six-operation integer ALU: widths, operation and status codes,
// the control struct between sequencer and iterative unit, and a helper function.
// No dependencies.
package ialu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int KIND_W     = 3;
  localparam int ST_W       = 2;
  localparam int IN_W       = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_W      = ((DATA_WIDTH + ST_W + 7) / 8) * 8;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0]   word_t;
  typedef logic [2*DATA_WIDTH-1:0] dword_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [OUT_W-1:0]        out_data_t;

  localparam word_t W_ONE     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  localparam word_t W_SIGN    = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t W_MAXP    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  // One above the most negative magnitude: marks a saturated product.
  localparam word_t W_SAT     = {1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1};
  localparam word_t SQRT_BIT0 = {2'b01, {(DATA_WIDTH-2){1'b0}}};

  localparam cnt_t DIV_LAST  = cnt_t'(DATA_WIDTH - 1);
  localparam cnt_t SQRT_LAST = cnt_t'(DATA_WIDTH / 2 - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_POW  = 3'd4,
    KIND_SQRT = 3'd5
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_DIVZ   = 2'd1,
    ST_DOMAIN = 2'd2,
    ST_OVF    = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_ctl_t;

  function automatic word_t mag(input word_t v);
    return v[DATA_WIDTH-1] ? (~v + W_ONE) : v;
  endfunction

endpackage

>>> hdl/integer_six_op_alu_unit.sv
// Six-operation signed integer ALU: add, subtract, multiply, divide, power, square root.
// Top level; depends on ialu_pkg, ialu_mul and ialu_iter.
//
// Usage: one operation per input transfer. in_tuser carries the operation kind,
// in_tdata the two operands. One result transfer follows for every input transfer,
// holding the signed result and a status code (ok, divide by zero, domain, overflow).
// in_tready is high only while the sequencer is idle; it drops for the whole
// operation and rises once the result sits in the output register.
// Path from an input transfer to the result register, by kind:
//   add, subtract, special cases and unused kinds: decode state, then output state
//   multiply: one pass through the registered multiplier
//   divide, square root: one bit per cycle in the shared subtract unit
//   power: per exponent bit a check state, a multiply state for a set bit and a squaring
//   state in the shared multiplier; saturation and bases 0 and 1 end the loop early.
// The next input transfer is taken the cycle after the result is registered, so a
// new item is not taken before the last one is done.
// When the receiver stalls, the result waits in the output register and one more
// item may be taken and computed; it then holds until the register is free.
// A synchronous reset drops out_tvalid and returns the sequencer to idle.
module integer_six_op_alu_unit import ialu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // operand_a, operand_b
  input  logic [KIND_W-1:0] in_tuser,  // kind
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // result_value, status, zero padding
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MULW,
    S_PCHK,
    S_PACC,
    S_PSQ,
    S_PFIN,
    S_ITER,
    S_OUT
  } state_t;

  state_t    state_r, state_nxt;
  kind_t     kind_r, kind_nxt;
  word_t     a_r, a_nxt;
  word_t     b_r, b_nxt;
  word_t     acc_r, acc_nxt;
  word_t     m_r, m_nxt;
  word_t     e_r, e_nxt;
  logic      neg_r, neg_nxt;
  word_t     res_r, res_nxt;
  status_t   st_r, st_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_data_t out_data_r, out_data_nxt;

  word_t     mul_x, mul_y;
  dword_t    prod;
  word_t     sat_val;
  iter_ctl_t iter_ctl;
  word_t     iter_x;
  word_t     iter_res;
  logic      iter_done;

  word_t     sum;
  word_t     dif;
  word_t     lim;

  ialu_mul u_mul (
    .clk     (clk),
    .op_x    (mul_x),
    .op_y    (mul_y),
    .prod_r  (prod),
    .sat_val (sat_val)
  );

  ialu_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (iter_ctl),
    .x      (iter_x),
    .d      (mag(b_r)),
    .done   (iter_done),
    .result (iter_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign sum       = a_r + b_r;
  assign dif       = a_r - b_r;
  assign lim       = neg_r ? W_SIGN : W_MAXP;
  assign iter_x    = (kind_r == KIND_SQRT) ? a_r : mag(a_r);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mul_x         = m_r;
    mul_y         = m_r;
    iter_ctl.start   = 1'b0;
    iter_ctl.is_sqrt = (kind_r == KIND_SQRT);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = kind_t'(in_tuser);
          a_nxt     = in_tdata[DATA_WIDTH-1:0];
          b_nxt     = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_nxt   = '0;
        st_nxt    = ST_OK;
        state_nxt = S_OUT;
        case (kind_r)
          KIND_ADD: begin
            res_nxt = sum;
            if ((a_r[DATA_WIDTH-1] == b_r[DATA_WIDTH-1]) &&
                (sum[DATA_WIDTH-1] != a_r[DATA_WIDTH-1])) begin
              st_nxt = ST_OVF;
            end
          end
          KIND_SUB: begin
            res_nxt = dif;
            if ((a_r[DATA_WIDTH-1] != b_r[DATA_WIDTH-1]) &&
                (dif[DATA_WIDTH-1] != a_r[DATA_WIDTH-1])) begin
              st_nxt = ST_OVF;
            end
          end
          KIND_MUL: begin
            mul_x     = mag(a_r);
            mul_y     = mag(b_r);
            neg_nxt   = a_r[DATA_WIDTH-1] ^ b_r[DATA_WIDTH-1];
            state_nxt = S_MULW;
          end
          KIND_DIV: begin
            if (b_r == '0) begin
              st_nxt = ST_DIVZ;
            end else if ((a_r == W_SIGN) && (b_r == '1)) begin
              res_nxt = W_SIGN;
              st_nxt  = ST_OVF;
            end else begin
              iter_ctl.start = 1'b1;
              neg_nxt        = a_r[DATA_WIDTH-1] ^ b_r[DATA_WIDTH-1];
              state_nxt      = S_ITER;
            end
          end
          KIND_POW: begin
            if (b_r[DATA_WIDTH-1]) begin
              // A negative exponent leaves only bases one and minus one nonzero.
              if (a_r == '0) begin
                st_nxt = ST_DOMAIN;
              end else if (a_r == W_ONE) begin
                res_nxt = W_ONE;
              end else if (a_r == '1) begin
                res_nxt = b_r[0] ? '1 : W_ONE;
              end
            end else begin
              neg_nxt   = a_r[DATA_WIDTH-1] & b_r[0];
              m_nxt     = mag(a_r);
              e_nxt     = b_r;
              acc_nxt   = W_ONE;
              state_nxt = S_PCHK;
            end
          end
          KIND_SQRT: begin
            if (a_r[DATA_WIDTH-1]) begin
              st_nxt = ST_DOMAIN;
            end else begin
              iter_ctl.start = 1'b1;
              neg_nxt        = 1'b0;
              state_nxt      = S_ITER;
            end
          end
          default: begin
            st_nxt = ST_DOMAIN;
          end
        endcase
      end
      S_MULW: begin
        res_nxt   = neg_r ? (~prod[DATA_WIDTH-1:0] + W_ONE) : prod[DATA_WIDTH-1:0];
        st_nxt    = ((prod[2*DATA_WIDTH-1:DATA_WIDTH] != '0) ||
                     (prod[DATA_WIDTH-1:0] > lim)) ? ST_OVF : ST_OK;
        state_nxt = S_OUT;
      end
      S_PCHK: begin
        // A spent exponent, bases zero and one and any saturated term fix the outcome at once.
        if (e_r == '0) begin
          state_nxt = S_PFIN;
        end else if (m_r == '0) begin
          acc_nxt   = '0;
          state_nxt = S_PFIN;
        end else if (m_r == W_ONE) begin
          state_nxt = S_PFIN;
        end else if ((acc_r > W_SIGN) || (m_r > W_SIGN)) begin
          acc_nxt   = W_SAT;
          state_nxt = S_PFIN;
        end else if (e_r[0]) begin
          mul_x     = acc_r;
          mul_y     = m_r;
          state_nxt = S_PACC;
        end else begin
          e_nxt     = e_r >> 1;
          state_nxt = S_PSQ;
        end
      end
      S_PACC: begin
        acc_nxt = sat_val;
        e_nxt   = e_r >> 1;
        if ((e_r >> 1) != '0) begin
          state_nxt = S_PSQ;
        end else begin
          state_nxt = S_PFIN;
        end
      end
      S_PSQ: begin
        m_nxt     = sat_val;
        state_nxt = S_PCHK;
      end
      S_PFIN: begin
        if (acc_r > lim) begin
          res_nxt = neg_r ? W_SIGN : W_MAXP;
          st_nxt  = ST_OVF;
        end else begin
          res_nxt = neg_r ? (~acc_r + W_ONE) : acc_r;
          st_nxt  = ST_OK;
        end
        state_nxt = S_OUT;
      end
      S_ITER: begin
        if (iter_done) begin
          res_nxt   = neg_r ? (~iter_res + W_ONE) : iter_res;
          st_nxt    = ST_OK;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = out_data_t'({st_r, res_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      acc_r       <= acc_nxt;
      m_r         <= m_nxt;
      e_r         <= e_nxt;
      neg_r       <= neg_nxt;
      res_r       <= res_nxt;
      st_r        <= st_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/ialu_mul.sv
// Shared registered multiplier of the ALU, used for multiply and for power.
// Depends on ialu_pkg.
module ialu_mul import ialu_pkg::*; (
  input  logic   clk,
  input  word_t  op_x,
  input  word_t  op_y,
  output dword_t prod_r,
  output word_t  sat_val
);

  dword_t x_ext;
  dword_t y_ext;

  assign x_ext = {{DATA_WIDTH{1'b0}}, op_x};
  assign y_ext = {{DATA_WIDTH{1'b0}}, op_y};

  always_ff @(posedge clk) begin
    prod_r <= x_ext * y_ext;
  end

  // Products past the most negative magnitude collapse to one marker value.
  assign sat_val = ((prod_r[2*DATA_WIDTH-1:DATA_WIDTH] != '0) ||
                    (prod_r[DATA_WIDTH-1:0] > W_SIGN)) ? W_SAT : prod_r[DATA_WIDTH-1:0];

endmodule

>>> hdl/ialu_iter.sv
// Iterative divide and square-root unit: one result bit per cycle on one shared
// subtractor, restoring division and digit-by-digit square root. Depends on ialu_pkg.
module ialu_iter import ialu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  iter_ctl_t ctl,
  input  word_t     x,
  input  word_t     d,
  output logic      done,
  output word_t     result
);

  logic  busy_r, busy_nxt;
  logic  done_r, done_nxt;
  logic  sqrt_r, sqrt_nxt;
  cnt_t  cnt_r, cnt_nxt;
  word_t rem_r, rem_nxt;
  word_t acc_r, acc_nxt;   // quotient (dividend shifts out on top) or root
  word_t aux_r, aux_nxt;   // divisor or current root bit

  logic [DATA_WIDTH:0]   minu;
  logic [DATA_WIDTH:0]   subt;
  logic [DATA_WIDTH+1:0] diff;
  logic                  ge;

  always_comb begin
    if (sqrt_r) begin
      minu = {1'b0, rem_r};
      subt = {1'b0, acc_r + aux_r};
    end else begin
      minu = {rem_r, acc_r[DATA_WIDTH-1]};
      subt = {1'b0, aux_r};
    end
    diff = {1'b0, minu} - {1'b0, subt};
    ge   = !diff[DATA_WIDTH+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    aux_nxt  = aux_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = ctl.is_sqrt;
      if (ctl.is_sqrt) begin
        cnt_nxt = SQRT_LAST;
        rem_nxt = x;
        acc_nxt = '0;
        aux_nxt = SQRT_BIT0;
      end else begin
        cnt_nxt = DIV_LAST;
        rem_nxt = '0;
        acc_nxt = x;
        aux_nxt = d;
      end
    end else if (busy_r) begin
      if (sqrt_r) begin
        rem_nxt = ge ? diff[DATA_WIDTH-1:0] : rem_r;
        acc_nxt = ge ? ((acc_r >> 1) + aux_r) : (acc_r >> 1);
        aux_nxt = aux_r >> 2;
      end else begin
        rem_nxt = ge ? diff[DATA_WIDTH-1:0] : minu[DATA_WIDTH-1:0];
        acc_nxt = {acc_r[DATA_WIDTH-2:0], ge};
      end
      cnt_nxt = cnt_r - cnt_t'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    aux_r  <= aux_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

>>> hdl/ialu_chk.sv
// Port-level checker for the six-operation integer ALU, bound to the top level.
// Depends on ialu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ialu_chk import ialu_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  logic [ST_W-1:0] out_st;

  assign out_st = out_tdata[DATA_WIDTH+ST_W-1:DATA_WIDTH];

  // Reset empties the output register.
  `IALU_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "output valid after reset")

  // A stalled result keeps its value until the transfer.
  `IALU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // An accepted item closes the input until its result is registered.
  `IALU_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "input reopened right after a transfer")

  // Divide by zero and domain errors carry a zero result.
  `IALU_ASSERT(a_error_zero, out_tvalid && (out_st == ST_DIVZ || out_st == ST_DOMAIN) |-> out_tdata[DATA_WIDTH-1:0] == '0, "error status with nonzero result")

endmodule

bind integer_six_op_alu_unit ialu_chk u_ialu_chk (.*);
